/* src/tbc_pkg.sv */
// ============================================================================
// tbc_pkg: shared types and constants for the trajectory box crossing unit
// Point and result payload structs, register map codes, box reset bounds.
// ============================================================================
package tbc_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int NUM_AXES   = 3;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    // Register map, word index = paddr[4:2]
    localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic signed [COORD_BITS-1:0] BOX_MIN_X_RST = -COORD_BITS'(3200);
    localparam logic signed [COORD_BITS-1:0] BOX_MIN_Y_RST = -COORD_BITS'(3200);
    localparam logic signed [COORD_BITS-1:0] BOX_MIN_Z_RST = COORD_BITS'(0);
    localparam logic signed [COORD_BITS-1:0] BOX_MAX_X_RST = COORD_BITS'(3200);
    localparam logic signed [COORD_BITS-1:0] BOX_MAX_Y_RST = COORD_BITS'(3200);
    localparam logic signed [COORD_BITS-1:0] BOX_MAX_Z_RST = COORD_BITS'(8000);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic                         first_point;
        logic                         last_point;
    } point_t;

    typedef struct packed {
        logic point_or_segment_hit;
        logic crossed_so_far;
        logic trajectory_done;
    } result_t;

    // Per-item flags carried down the pipeline
    typedef struct packed {
        logic in_box;
        logic seg_en;
        logic first_point;
        logic last_point;
    } tag_t;

    // The two axes other than axis a, in ascending order
    function automatic int other_axis(input int a, input int k);
        int r;
        if (k == 0)
            r = (a == 0) ? 1 : 0;
        else
            r = (a == 2) ? 1 : 2;
        return r;
    endfunction

endpackage

/* src/trajectory_box_crossing_unit.sv */
// ============================================================================
// trajectory_box_crossing_unit
// Flags trajectory points inside an axis-aligned box and segments that cross
// one of its faces, with a sticky per-trajectory crossed flag.
// ============================================================================
// One point is accepted per clock while out_ready does not hold back the output,
// and it passes an input register, a difference stage, a product stage
// (24 parallel 25x25 signed multipliers forming the exact face-crossing cross
// products) and the result register, where the compares are resolved. Each
// stage moves on when the one after it is empty or moving, so empty stages
// keep taking points while a finished result waits. Box bounds are written
// through the APB port at byte addresses 0x00..0x14 (min x, y, z, then max
// x, y, z); write them only while no point is in flight.
module trajectory_box_crossing_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tbc_pkg::point_t                      in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tbc_pkg::result_t                     out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tbc_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [tbc_pkg::DATA_BITS-1:0]        pwdata,
    output logic [tbc_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready
);

    localparam int CW = tbc_pkg::COORD_BITS;
    localparam int DW = tbc_pkg::DIFF_BITS;
    localparam int PW = tbc_pkg::PROD_BITS;
    localparam int NA = tbc_pkg::NUM_AXES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0] box_min_reg [NA];
    logic signed [CW-1:0] box_max_reg [NA];
    logic                 cfg_write;
    logic [2:0]           cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg[0] <= tbc_pkg::BOX_MIN_X_RST;
            box_min_reg[1] <= tbc_pkg::BOX_MIN_Y_RST;
            box_min_reg[2] <= tbc_pkg::BOX_MIN_Z_RST;
            box_max_reg[0] <= tbc_pkg::BOX_MAX_X_RST;
            box_max_reg[1] <= tbc_pkg::BOX_MAX_Y_RST;
            box_max_reg[2] <= tbc_pkg::BOX_MAX_Z_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tbc_pkg::REG_BOX_MIN_X: box_min_reg[0] <= pwdata[CW-1:0];
                tbc_pkg::REG_BOX_MIN_Y: box_min_reg[1] <= pwdata[CW-1:0];
                tbc_pkg::REG_BOX_MIN_Z: box_min_reg[2] <= pwdata[CW-1:0];
                tbc_pkg::REG_BOX_MAX_X: box_max_reg[0] <= pwdata[CW-1:0];
                tbc_pkg::REG_BOX_MAX_Y: box_max_reg[1] <= pwdata[CW-1:0];
                tbc_pkg::REG_BOX_MAX_Z: box_max_reg[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            tbc_pkg::REG_BOX_MIN_X: prdata = tbc_pkg::DATA_BITS'(box_min_reg[0]);
            tbc_pkg::REG_BOX_MIN_Y: prdata = tbc_pkg::DATA_BITS'(box_min_reg[1]);
            tbc_pkg::REG_BOX_MIN_Z: prdata = tbc_pkg::DATA_BITS'(box_min_reg[2]);
            tbc_pkg::REG_BOX_MAX_X: prdata = tbc_pkg::DATA_BITS'(box_max_reg[0]);
            tbc_pkg::REG_BOX_MAX_Y: prdata = tbc_pkg::DATA_BITS'(box_max_reg[1]);
            tbc_pkg::REG_BOX_MAX_Z: prdata = tbc_pkg::DATA_BITS'(box_max_reg[2]);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic in_xfer;

    assign s4_ready = !out_valid || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                out_valid <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Previous point, updated at every input transfer
    // ------------------------------------------------------------------
    logic signed [CW-1:0] prev_reg [NA];
    logic                 have_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg[0]   <= '0;
            prev_reg[1]   <= '0;
            prev_reg[2]   <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            prev_reg[0]   <= in_data.point_x;
            prev_reg[1]   <= in_data.point_y;
            prev_reg[2]   <= in_data.point_z;
            have_prev_reg <= !in_data.last_point;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register with the previous point alongside
    // ------------------------------------------------------------------
    logic signed [CW-1:0] s1_cur_reg  [NA];
    logic signed [CW-1:0] s1_prev_reg [NA];
    logic                 s1_seg_en_reg;
    logic                 s1_first_reg;
    logic                 s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_cur_reg[0]  <= in_data.point_x;
            s1_cur_reg[1]  <= in_data.point_y;
            s1_cur_reg[2]  <= in_data.point_z;
            s1_prev_reg[0] <= prev_reg[0];
            s1_prev_reg[1] <= prev_reg[1];
            s1_prev_reg[2] <= prev_reg[2];
            s1_seg_en_reg  <= have_prev_reg && !in_data.first_point;
            s1_first_reg   <= in_data.first_point;
            s1_last_reg    <= in_data.last_point;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: differences against the previous point, inside test
    // ------------------------------------------------------------------
    logic signed [DW-1:0] d_reg    [NA];   // cur - prev
    logic signed [DW-1:0] nmin_reg [NA];   // box_min - prev
    logic signed [DW-1:0] nmax_reg [NA];   // box_max - prev
    logic [NA-1:0]        box_ok_reg;
    tbc_pkg::tag_t        s2_tag_reg;
    logic [NA-1:0]        in_axis;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
            in_axis[i] = (s1_cur_reg[i] >= box_min_reg[i]) && (s1_cur_reg[i] <= box_max_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            for (int i = 0; i < NA; i++)
            begin
                d_reg[i]      <= DW'(s1_cur_reg[i]) - DW'(s1_prev_reg[i]);
                nmin_reg[i]   <= DW'(box_min_reg[i]) - DW'(s1_prev_reg[i]);
                nmax_reg[i]   <= DW'(box_max_reg[i]) - DW'(s1_prev_reg[i]);
                box_ok_reg[i] <= box_min_reg[i] <= box_max_reg[i];
            end
            s2_tag_reg.in_box      <= &in_axis;
            s2_tag_reg.seg_en      <= s1_seg_en_reg;
            s2_tag_reg.first_point <= s1_first_reg;
            s2_tag_reg.last_point  <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products and face fraction range checks
    // ------------------------------------------------------------------
    logic signed [PW-1:0] lo_prod_reg   [NA][2];  // (min_b - prev_b) * d_a
    logic signed [PW-1:0] hi_prod_reg   [NA][2];  // (max_b - prev_b) * d_a
    logic signed [PW-1:0] qmin_prod_reg [NA][2];  // (min_a - prev_a) * d_b
    logic signed [PW-1:0] qmax_prod_reg [NA][2];  // (max_a - prev_a) * d_b
    logic [NA-1:0]        dpos_reg;
    logic [NA-1:0]        face_min_ok_reg;
    logic [NA-1:0]        face_max_ok_reg;
    tbc_pkg::tag_t        s3_tag_reg;
    logic [NA-1:0]        face_min_ok;
    logic [NA-1:0]        face_max_ok;

    // Fraction strictly inside (0,1): n on the same side of zero as d, below |d|
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (d_reg[i] > 0)
            begin
                face_min_ok[i] = (nmin_reg[i] > 0) && (nmin_reg[i] < d_reg[i]);
                face_max_ok[i] = (nmax_reg[i] > 0) && (nmax_reg[i] < d_reg[i]);
            end
            else if (d_reg[i] < 0)
            begin
                face_min_ok[i] = (nmin_reg[i] < 0) && (nmin_reg[i] > d_reg[i]);
                face_max_ok[i] = (nmax_reg[i] < 0) && (nmax_reg[i] > d_reg[i]);
            end
            else
            begin
                face_min_ok[i] = 1'b0;
                face_max_ok[i] = 1'b0;
            end
        end
    end

    for (genvar a = 0; a < NA; a++)
    begin : g_axis
        for (genvar k = 0; k < 2; k++)
        begin : g_other
            localparam int B = tbc_pkg::other_axis(a, k);

            always_ff @(posedge clk)
            begin
                if (s3_ready)
                begin
                    lo_prod_reg[a][k]   <= nmin_reg[B] * d_reg[a];
                    hi_prod_reg[a][k]   <= nmax_reg[B] * d_reg[a];
                    qmin_prod_reg[a][k] <= nmin_reg[a] * d_reg[B];
                    qmax_prod_reg[a][k] <= nmax_reg[a] * d_reg[B];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            for (int i = 0; i < NA; i++)
                dpos_reg[i] <= d_reg[i] > 0;
            face_min_ok_reg <= face_min_ok & box_ok_reg;
            face_max_ok_reg <= face_max_ok & box_ok_reg;
            s3_tag_reg      <= s2_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: crossing point within the box on the other two axes
    // ------------------------------------------------------------------
    logic [NA-1:0] cross_min;
    logic [NA-1:0] cross_max;
    logic          hit;
    logic          crossed_reg;
    logic          crossed_next;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            cross_min[i] = face_min_ok_reg[i];
            cross_max[i] = face_max_ok_reg[i];
            for (int k = 0; k < 2; k++)
            begin
                // Negative direction flips both inequalities
                if (dpos_reg[i])
                begin
                    cross_min[i] &= (lo_prod_reg[i][k] <= qmin_prod_reg[i][k])
                                 && (qmin_prod_reg[i][k] <= hi_prod_reg[i][k]);
                    cross_max[i] &= (lo_prod_reg[i][k] <= qmax_prod_reg[i][k])
                                 && (qmax_prod_reg[i][k] <= hi_prod_reg[i][k]);
                end
                else
                begin
                    cross_min[i] &= (lo_prod_reg[i][k] >= qmin_prod_reg[i][k])
                                 && (qmin_prod_reg[i][k] >= hi_prod_reg[i][k]);
                    cross_max[i] &= (lo_prod_reg[i][k] >= qmax_prod_reg[i][k])
                                 && (qmax_prod_reg[i][k] >= hi_prod_reg[i][k]);
                end
            end
        end
        hit          = s3_tag_reg.in_box
                    || (s3_tag_reg.seg_en && ((|cross_min) || (|cross_max)));
        crossed_next = (crossed_reg && !s3_tag_reg.first_point) || hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crossed_reg <= 1'b0;
        else if (s4_ready && s3_valid_reg)
            crossed_reg <= crossed_next;
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            out_data.point_or_segment_hit <= hit;
            out_data.crossed_so_far       <= crossed_next;
            out_data.trajectory_done      <= s3_tag_reg.last_point;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hit_sets_crossed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.point_or_segment_hit |-> out_data.crossed_so_far)
        else $error("hit reported without crossed flag");

    a_last_drops_prev: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.last_point |=> !have_prev_reg)
        else $error("previous point kept past end of trajectory");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s4_ready && s3_valid_reg && s3_tag_reg.first_point && !hit
        |=> !crossed_reg && !out_data.crossed_so_far)
        else $error("crossed flag not cleared at trajectory start");

    a_flag_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s4_ready && s3_valid_reg) |-> crossed_reg == out_data.crossed_so_far)
        else $error("sticky flag out of step with result");

endmodule
